>>> src/tmprng_pkg.sv
// Shared types and constants for the table-mixing random word generator.
// Used by tmprng_tbl, tmprng_mul and table_mixing_prng_top.
package tmprng_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 16;
  localparam int WORD_W      = 32;

  // Operation codes
  localparam logic [1:0] OP_RELOAD = 2'd0;
  localparam logic [1:0] OP_SEED   = 2'd1;
  localparam logic [1:0] OP_DRAW   = 2'd2;

  localparam logic [WORD_W-1:0]  SEED_MULT = 32'h3C6E_F35F;
  localparam logic [ENTRY_W-1:0] LFSR_TAPS = 16'hB400;

  // Table contents after reset and after reload
  localparam logic [ENTRY_W-1:0] DEFAULT_TABLE [TABLE_DEPTH] = '{
    16'd1, 16'd4, 16'd1, 16'd5, 16'd9, 16'd2, 16'd6, 16'd5,
    16'd3, 16'd5, 16'd8, 16'd9, 16'd7, 16'd9, 16'd3, 16'd2
  };

  typedef struct packed {
    logic [1:0]        operation;
    logic [WORD_W-1:0] seed_value;
  } cmd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic              word_valid;
  } res_item_t;

  // Table port controls from the sequencer
  typedef struct packed {
    logic               clear;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
  } tbl_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_SI, S_SL, S_SM, S_SW, S_SA, S_SB,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8,
    S_EMIT
  } state_t;

endpackage

>>> src/tmprng_tbl.sv
// Mixing table: one write port, one registered read port with write-first bypass.
// Entries not written since reset or reload read as the default table.
// Depends on tmprng_pkg.
module tmprng_tbl (
  input  logic                         clk,
  input  logic                         rst,
  input  tmprng_pkg::tbl_ctrl_t        ctrl,
  output logic [tmprng_pkg::ENTRY_W-1:0] rd_data
);
  import tmprng_pkg::*;

  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;

  // Track written entries; reload drops them all at once
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[ctrl.wr_addr] <= 1'b1;
    end
  end

  // Store write data
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
  end

  // Register read data, newest write first
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_addr == ctrl.rd_addr) begin
      rd_data <= ctrl.wr_data;
    end else if (valid[ctrl.rd_addr]) begin
      rd_data <= mem[ctrl.rd_addr];
    end else begin
      rd_data <= DEFAULT_TABLE[ctrl.rd_addr];
    end
  end

endmodule

>>> src/tmprng_mul.sv
// Shared 32x32 multiplier keeping the low 32 bits, product registered.
// Depends on tmprng_pkg.
module tmprng_mul (
  input  logic                          clk,
  input  logic [tmprng_pkg::WORD_W-1:0] opa,
  input  logic [tmprng_pkg::WORD_W-1:0] opb,
  output logic [tmprng_pkg::WORD_W-1:0] prod
);
  import tmprng_pkg::*;

  // Multiply modulo 2^32
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

endmodule

>>> src/table_mixing_prng_top.sv
// Table-mixing random word generator, top level with the operation sequencer.
// One item at a time, via S_LOAD for reload, S_D0 to S_D8 for draw, S_SI, S_SL and
// sixteen rounds of S_SM, S_SW, S_SA, S_SB for seed, straight to S_EMIT for the unused
// code. The result is registered on leaving S_EMIT; the next item is taken in the cycle
// after the result, and a waiting result holds S_EMIT.
// Synchronous reset restores the default table and clears seed word and index.
module table_mixing_prng_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  tmprng_pkg::cmd_item_t cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output tmprng_pkg::res_item_t res
);
  import tmprng_pkg::*;

  state_t state, state_next;

  logic [WORD_W-1:0]  seed_word;
  logic [WORD_W-1:0]  idx;
  logic [IDX_W-1:0]   round;
  logic [ENTRY_W-1:0] ea, eb, ec, ed, g, tm1;
  logic [WORD_W-1:0]  wrd;
  logic               wv;

  tbl_ctrl_t          tctl;
  logic [ENTRY_W-1:0] rd_data;
  logic [WORD_W-1:0]  mul_a, mul_b, prod;

  logic               cmd_take, emit_go;

  logic [IDX_W-1:0]   p0, p1, pm2, p2, wm1;
  logic [ENTRY_W-1:0] y1, x1, y2, x2, sel, lfsr, rot_c, rot_d;
  logic [ENTRY_W-1:0] seed_new, sum16;
  logic [WORD_W-1:0]  t1, t2, diff, wmix;
  logic [2*ENTRY_W-1:0] dbl_c, dbl_d;

  tmprng_tbl u_tbl (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tctl),
    .rd_data (rd_data)
  );

  tmprng_mul u_mul (
    .clk  (clk),
    .opa  (mul_a),
    .opb  (mul_b),
    .prod (prod)
  );

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign emit_go   = (state == S_EMIT) && (!res_valid || !res_stall);

  // Table slots around the index
  assign p0  = idx[IDX_W-1:0];
  assign p1  = p0 + IDX_W'(1);
  assign pm2 = p0 - IDX_W'(2);
  assign p2  = p0 + IDX_W'(2);
  assign wm1 = wrd[IDX_W-1:0] - IDX_W'(1);

  // Pair mixes of the draw
  assign y1 = ec ^ (ea << 5) ^ (ec >> 3) ^ (ea >> 1);
  assign x1 = ea ^ (y1 << 8) ^ (ea << 3) ^ (y1 << 9);
  assign y2 = ed ^ (x1 << 5) ^ (ed >> 3) ^ (x1 >> 1);
  assign x2 = x1 ^ (y2 << 8) ^ (x1 << 3) ^ (y2 << 9);

  // Rotate mix; the slot before the word may be the not yet written first slot
  assign dbl_c = {ec, ec} << wrd[IDX_W-1:0];
  assign dbl_d = {ed, ed} << wrd[IDX_W-1:0];
  assign rot_c = dbl_c[2*ENTRY_W-1:ENTRY_W];
  assign rot_d = dbl_d[2*ENTRY_W-1:ENTRY_W];
  assign sel   = (wm1 == p0) ? x2 : rd_data;

  // Galois step of the second entry
  assign lfsr = (eb >> 1) ^ (eb[0] ? LFSR_TAPS : '0);

  // Output word before registering
  assign wmix = prod ^ {16'h0, ea} ^ {8'h0, eb, 8'h0} ^ {ec, 16'h0}
              ^ {24'h0, ed[7:0]} ^ {ed[15:8], 24'h0};

  // Seed round terms
  assign t1       = (prod - idx) ^ seed_word;
  assign t2       = (prod + idx) ^ seed_word;
  assign seed_new = rd_data ^ t1[WORD_W-1:ENTRY_W] ^ t2[ENTRY_W-1:0];
  assign sum16    = tm1 + g;
  assign diff     = {16'h0, rd_data} - {16'h0, g};

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          if (cmd.operation == OP_RELOAD) begin
            state_next = S_LOAD;
          end else if (cmd.operation == OP_SEED) begin
            state_next = S_SI;
          end else if (cmd.operation == OP_DRAW) begin
            state_next = S_D0;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_LOAD: state_next = S_EMIT;
      S_SI:   state_next = S_SL;
      S_SL:   state_next = S_SM;
      S_SM:   state_next = S_SW;
      S_SW:   state_next = S_SA;
      S_SA:   state_next = S_SB;
      S_SB:   state_next = (round == IDX_W'(TABLE_DEPTH - 1)) ? S_EMIT : S_SM;
      S_D0:   state_next = S_D1;
      S_D1:   state_next = S_D2;
      S_D2:   state_next = S_D3;
      S_D3:   state_next = S_D4;
      S_D4:   state_next = S_D5;
      S_D5:   state_next = S_D6;
      S_D6:   state_next = S_D7;
      S_D7:   state_next = S_D8;
      S_D8:   state_next = S_EMIT;
      S_EMIT: state_next = emit_go ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // Drive table port and multiplier operands
  always_comb begin
    tctl  = '0;
    mul_a = seed_word;
    mul_b = idx;
    unique case (state)
      S_LOAD: tctl.clear = 1'b1;
      S_SI:   mul_b = SEED_MULT;
      S_SM:   tctl.rd_addr = round;
      S_SW: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = round;
        tctl.wr_data = seed_new;
        tctl.rd_addr = p0 - IDX_W'(1);
      end
      S_SA:   tctl.rd_addr = p0 + IDX_W'(1);
      S_D0:   tctl.rd_addr = p0;
      S_D1:   tctl.rd_addr = p1;
      S_D2:   tctl.rd_addr = pm2;
      S_D3:   tctl.rd_addr = p2;
      S_D4: begin
        mul_a = {16'h0, ea} + idx;
        mul_b = {16'h0, eb} - seed_word;
      end
      S_D5: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = pm2;
        tctl.wr_data = y1;
      end
      S_D6: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = p2;
        tctl.wr_data = y2;
        tctl.rd_addr = wm1;
      end
      S_D7: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = p0;
        tctl.wr_data = sel ^ rot_c ^ rot_d ^ ea;
      end
      S_D8: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = p1;
        tctl.wr_data = lfsr;
      end
      default: begin
      end
    endcase
  end

  // Hold state, seed word, index and round count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seed_word <= '0;
      idx       <= '0;
      round     <= '0;
    end else begin
      state <= state_next;
      if (cmd_take && cmd.operation == OP_SEED) begin
        seed_word <= cmd.seed_value;
      end
      case (state)
        S_SL: begin
          idx   <= prod;
          round <= '0;
        end
        S_SB: begin
          idx   <= idx ^ {sum16, 16'h0} ^ diff;
          round <= round + IDX_W'(1);
        end
        S_D8:    idx <= idx + WORD_W'(2);
        default: begin
        end
      endcase
    end
  end

  // Capture table reads and the drawn word
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      wrd <= '0;
      wv  <= 1'b0;
    end
    case (state)
      S_SW: g   <= seed_new;
      S_SA: tm1 <= rd_data;
      S_D1: ea  <= rd_data;
      S_D2: eb  <= rd_data;
      S_D3: ec  <= rd_data;
      S_D4: ed  <= rd_data;
      S_D5: wrd <= wmix;
      S_D8: wv  <= 1'b1;
      default: begin
      end
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res.random_word <= wrd;
      res.word_valid  <= wv;
    end
  end

endmodule
